// ===== design/dsqrt_pkg.sv =====
// Package with shared types and constants for the bit-serial double square root.
package dsqrt_pkg;

  localparam logic [1:0] RmNearest = 2'd0;
  localparam logic [1:0] RmZero    = 2'd1;
  localparam logic [1:0] RmDown    = 2'd2;
  localparam logic [1:0] RmUp      = 2'd3;

  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;
  localparam int unsigned RootBits = 54;
  localparam logic [10:0] ExpBias  = 11'd1023;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the operand and classify it
    logic norm;    // one step of subnormal normalization
    logic align;   // make the exponent even
    logic iter;    // one root bit of the recurrence
    logic round;   // form the final result
  } dsqrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;  // result already known after load
    logic normed;   // hidden bit is set
    logic last;     // final root bit being produced
  } dsqrt_sts_t;

endpackage

// ===== design/dsqrt_datapath.sv =====
// Datapath of the square root: classification, normalization, recurrence and rounding.
module dsqrt_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsqrt_pkg::dsqrt_cmd_t cmd_i,
  output dsqrt_pkg::dsqrt_sts_t sts_o,
  input  logic [63:0]           operand_bits_i,
  input  logic [1:0]            rounding_mode_i,
  output logic [63:0]           root_bits_o,
  output logic                  invalid_flag_o,
  output logic                  inexact_flag_o
);

  localparam logic [10:0] ExpBiasW = dsqrt_pkg::ExpBias;

  logic [53:0] mant_q, mant_d;
  logic [55:0] rem_q, rem_d;
  logic [53:0] root_q, root_d;
  logic [12:0] exp_q, exp_d;   // signed unbiased exponent
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] res_q, res_d;
  logic        inv_q, inv_d, inx_q, inx_d, spec_q, spec_d;

  logic [10:0] efield;
  logic [51:0] frac;
  logic [55:0] rem_sh, trial;
  logic [52:0] sig;
  logic        rbit, sticky, inexact, inc;
  logic [12:0] half_e;

  assign efield = operand_bits_i[62:52];
  assign frac   = operand_bits_i[51:0];
  assign rem_sh = {rem_q[53:0], mant_q[53:52]};
  assign trial  = {root_q[53:0], 2'b01};
  assign sig    = root_q[53:1];
  assign rbit   = root_q[0];
  assign sticky = rem_q != '0;
  assign inexact = rbit | sticky;
  assign half_e = {exp_q[12], exp_q[12:1]};

  always_comb begin
    case (rounding_mode_i)
      dsqrt_pkg::RmNearest: inc = rbit & (sticky | sig[0]);
      dsqrt_pkg::RmUp:      inc = inexact;
      default:              inc = 1'b0;
    endcase
  end

  // Next-state logic, one command at a time.
  always_comb begin
    mant_d = mant_q; rem_d = rem_q; root_d = root_q; exp_d = exp_q;
    cnt_d = cnt_q; res_d = res_q; inv_d = inv_q; inx_d = inx_q; spec_d = spec_q;
    if (cmd_i.load) begin
      inv_d = 1'b0; inx_d = 1'b0; spec_d = 1'b1; res_d = operand_bits_i;
      rem_d = '0; root_d = '0; cnt_d = '0;
      mant_d = {1'b0, (efield != 11'd0), frac};
      exp_d = (efield == 11'd0) ? (13'd1 - {2'b0, ExpBiasW})
                                : ({2'b0, efield} - {2'b0, ExpBiasW});
      if (efield == 11'h7FF) begin
        if (frac != '0) res_d = operand_bits_i | dsqrt_pkg::QuietBit;
        else if (operand_bits_i[63]) begin
          res_d = dsqrt_pkg::CanonNan; inv_d = 1'b1;
        end
      end else if (operand_bits_i[62:0] == '0) begin
        res_d = operand_bits_i;
      end else if (operand_bits_i[63]) begin
        res_d = dsqrt_pkg::CanonNan; inv_d = 1'b1;
      end else begin
        spec_d = 1'b0;
      end
    end
    if (cmd_i.norm) begin
      mant_d = {mant_q[52:0], 1'b0};
      exp_d  = exp_q - 13'd1;
    end
    if (cmd_i.align && exp_q[0]) begin
      mant_d = {mant_q[52:0], 1'b0};
      exp_d  = exp_q - 13'd1;
    end
    if (cmd_i.iter) begin
      mant_d = {mant_q[51:0], 2'b00};
      cnt_d  = cnt_q + 6'd1;
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial; root_d = {root_q[52:0], 1'b1};
      end else begin
        rem_d = rem_sh; root_d = {root_q[52:0], 1'b0};
      end
    end
    if (cmd_i.round) begin
      res_d = ({51'b0, 13'(half_e + 13'(dsqrt_pkg::ExpBias))} << 52)
            + {12'b0, sig[51:0]} + {63'b0, inc};
      inx_d = inexact;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      spec_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      spec_q <= spec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q <= mant_d; rem_q <= rem_d; root_q <= root_d; exp_q <= exp_d;
    res_q <= res_d; inv_q <= inv_d; inx_q <= inx_d;
  end

  assign sts_o.special = spec_q;
  assign sts_o.normed  = mant_q[52];
  assign sts_o.last    = cnt_q == 6'(dsqrt_pkg::RootBits - 1);
  assign root_bits_o    = res_q;
  assign invalid_flag_o = inv_q;
  assign inexact_flag_o = inx_q;

endmodule

// ===== design/dsqrt_ctrl.sv =====
// Controller state machine sequencing the square-root datapath.
module dsqrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dsqrt_pkg::dsqrt_sts_t sts_i,
  output dsqrt_pkg::dsqrt_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClass = 3'd1;
  localparam logic [2:0] StNorm  = 3'd2;
  localparam logic [2:0] StIter  = 3'd3;
  localparam logic [2:0] StRound = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;

  // The input is free once the previous result has been taken.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = StClass;
      end
      StClass: state_d = sts_i.special ? StOut : StNorm;
      StNorm: begin
        if (sts_i.normed) begin
          cmd_o.align = 1'b1; state_d = StIter;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      StIter: begin
        cmd_o.iter = 1'b1;
        if (sts_i.last) state_d = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1; state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule

// ===== design/double_sqrt_bit_serial.sv =====
// Top level of the bit-serial IEEE double square root.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | in_valid_i / in_ready_o   | operand_bits_i
//  output   | out_valid_o / out_ready_i | root_bits_o, invalid_flag_o, inexact_flag_o
//  config   | cfg_we_i                  | cfg_wdata_i (rounding mode)
//
// From accepting the beat to output valid, a normal operand is classified, aligned once,
// run through the recurrence for 54 root bits (one per step) and rounded.
// A subnormal is first normalised, one shift per leading zero of its fraction plus one.
// Special cases go from classification straight to output valid.
// One item is in flight at a time; the next beat is accepted once the result is taken.
// Reset clears the controller and sets the rounding mode to nearest even.
module double_sqrt_bit_serial (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] root_bits_o,
  output logic        invalid_flag_o,
  output logic        inexact_flag_o
);

  logic [1:0] rmode_q;
  dsqrt_pkg::dsqrt_cmd_t cmd;
  dsqrt_pkg::dsqrt_sts_t sts;

  // Rounding mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rmode_q <= dsqrt_pkg::RmNearest;
    else if (cfg_we_i) rmode_q <= cfg_wdata_i;
  end

  dsqrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dsqrt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .operand_bits_i,
    .rounding_mode_i(rmode_q), .root_bits_o, .invalid_flag_o, .inexact_flag_o
  );

endmodule

// ===== sim/double_sqrt_bit_serial_test.sv =====
// Testbench for the bit-serial IEEE double square root with its own root predictor.
`timescale 1ns / 100ps

module double_sqrt_bit_serial_test;

  typedef struct packed {
    logic [63:0] root;
    logic        invalid;
    logic        inexact;
  } root_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = dsqrt_pkg::RmNearest;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] operand_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] root_bits_o;
  logic        invalid_flag_o;
  logic        inexact_flag_o;

  logic [1:0]   round_mode = dsqrt_pkg::RmNearest;
  root_result_t roots_due[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           take_stall_pct = 0;
  int           hold_off_cycles = 0;

  always #4 clk_i = ~clk_i;

  double_sqrt_bit_serial dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .operand_bits_i, .out_valid_o, .out_ready_i, .root_bits_o,
    .invalid_flag_o, .inexact_flag_o
  );

  // Predicts the correctly rounded root and flags for one operand.
  function automatic root_result_t predict_root(logic [63:0] x, logic [1:0] mode);
    root_result_t r;
    logic [10:0]  ef;
    logic [51:0]  fr;
    logic [63:0]  mant, rem, q, trial, pair, sig, inc;
    logic         rbit, sticky;
    int           e, sh;
    ef = x[62:52];
    fr = x[51:0];
    r = '0;
    if (ef == 11'h7FF) begin
      if (fr != 0) r.root = x | dsqrt_pkg::QuietBit;
      else if (x[63]) begin
        r.root = dsqrt_pkg::CanonNan;
        r.invalid = 1'b1;
      end else r.root = x;
      return r;
    end
    if (x[62:0] == 0) begin
      r.root = x;
      return r;
    end
    if (x[63]) begin
      r.root = dsqrt_pkg::CanonNan;
      r.invalid = 1'b1;
      return r;
    end
    // Normalise the significand so that the hidden bit is set.
    if (ef == 0) begin
      mant = {12'd0, fr};
      sh = 0;
      while (!mant[52]) begin
        mant = mant << 1;
        sh++;
      end
      e = 1 - sh - 1023;
    end else begin
      mant = {12'd1, fr};
      e = int'(ef) - 1023;
    end
    if (e % 2 != 0) begin
      mant = mant << 1;
      e = e - 1;
    end
    // Restoring recurrence, one root bit per step.
    rem = 0;
    q = 0;
    for (int i = 0; i < 54; i++) begin
      pair = (i < 27) ? ((mant >> (52 - 2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (q << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        q = (q << 1) | 64'd1;
      end else q = q << 1;
    end
    sig = q >> 1;
    rbit = q[0];
    sticky = rem != 0;
    r.inexact = rbit | sticky;
    inc = 0;
    if (mode == dsqrt_pkg::RmNearest) inc = (rbit && (sticky || sig[0])) ? 64'd1 : 64'd0;
    else if (mode == dsqrt_pkg::RmUp) inc = r.inexact ? 64'd1 : 64'd0;
    r.root = (64'(e / 2 + 1023) << 52) + (sig - 64'h0010_0000_0000_0000) + inc;
    return r;
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= take_stall_pct);
  end

  // Compares each result beat with the oldest expected root.
  always @(posedge clk_i) begin
    root_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (roots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", root_bits_o);
      end else begin
        want = roots_due.pop_front();
        if (want.root !== root_bits_o || want.invalid !== invalid_flag_o ||
            want.inexact !== inexact_flag_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("root mismatch: expected %h inv %b inx %b, got %h inv %b inx %b",
                     want.root, want.invalid, want.inexact, root_bits_o,
                     invalid_flag_o, inexact_flag_o);
        end
      end
    end
  end

  // Sends one operand beat, with a random idle gap first. Valid stays high
  // between beats sent back to back.
  task automatic send_operand(logic [63:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    operand_bits_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    roots_due.push_back(predict_root(x, round_mode));
  endtask

  task automatic drain_roots();
    in_valid_i <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic set_rounding(logic [1:0] mode);
    drain_roots();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    round_mode = mode;
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(9))
      0: x[62:52] = 11'h7FF;
      1: x[62:52] = 11'h000;
      2: x[63] = 1'b1;
      default: x[63] = 1'b0;
    endcase
    return x;
  endfunction

  // Zeros, infinities, NaNs, negatives, subnormals and rounding carries.
  task automatic test_special_cases();
    logic [63:0] ops[$];
    ops = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
            64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
            64'h7FF0_0000_0000_0001, 64'hFFF4_0000_0000_0000,
            64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
            64'h0010_0000_0000_0000, 64'h3FF0_0000_0000_0000,
            64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000,
            64'h7FEF_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF,
            64'h4022_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA};
    foreach (ops[i]) send_operand(ops[i]);
  endtask

  task automatic test_rounding_modes();
    logic [1:0] modes[4];
    modes = '{dsqrt_pkg::RmZero, dsqrt_pkg::RmDown, dsqrt_pkg::RmUp,
              dsqrt_pkg::RmNearest};
    foreach (modes[m]) begin
      set_rounding(modes[m]);
      repeat (30) send_operand(random_operand());
    end
  endtask

  task automatic test_random_pacing();
    int idle[4];
    int stall[4];
    idle = '{0, 82, 0, 19};
    stall = '{0, 0, 82, 19};
    for (int p = 0; p < 4; p++) begin
      set_rounding(2'($urandom_range(3)));
      send_idle_pct = idle[p];
      take_stall_pct = stall[p];
      repeat (220) send_operand(random_operand());
    end
    send_idle_pct = 0;
    take_stall_pct = 0;
  endtask

  // The receiver holds off while the sender keeps offering, then a full pause.
  task automatic test_back_pressure();
    hold_off_cycles = 400;
    repeat (20) send_operand(random_operand());
    drain_roots();
    repeat (20) send_operand(random_operand());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_rounding_modes();
    test_back_pressure();
    test_random_pacing();
    drain_roots();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
